// ===== rtl/core/lsu_pkg.sv =====
`default_nettype none
package lsu_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned NUM_REGS      = 32;
  localparam int unsigned S_TDATA_W     = 184;
  localparam int unsigned M_TDATA_W     = 128;

  // instruction bit positions
  localparam int unsigned BIT_GROUP = 31;
  localparam int unsigned BIT_WIDE  = 30;
  localparam int unsigned BIT_UOFF  = 24;
  localparam int unsigned BIT_LOAD  = 22;
  localparam int unsigned BIT_ROFF  = 21;
  localparam int unsigned BIT_PRE   = 11;

  typedef enum logic [1:0] {
    KIND_EXEC = 2'd0,
    KIND_WREG = 2'd1,
    KIND_WMEM = 2'd2
  } kind_e;

  function automatic logic [63:0] sext9(input logic [8:0] v);
    sext9 = {{55{v[8]}}, v};
  endfunction

  function automatic logic [63:0] sext19x4(input logic [18:0] v);
    sext19x4 = {{43{v[18]}}, v, 2'b00};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lsu_ram.sv =====
`default_nettype none
module lsu_ram #(
  parameter int unsigned WIDTH = lsu_pkg::DATA_W,
  parameter int unsigned DEPTH = lsu_pkg::NUM_REGS,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/load_store_unit_exec.sv =====
`default_nettype none
// sequence: preload and unused kinds pass S_PRE and S_DONE; an instruction passes S_RDN and
// S_RDM (register reads), S_ADDR, S_WB in writeback modes, S_RDT and S_GETT for stores, S_MEM
// over the access bytes, S_RFW for loads and S_DONE, where it stays while a result waits
// throughput: one word at a time, next word taken the cycle after the result is registered
// reset: control clears at once, register file reads zero through valid bits, then the
// byte memory (MEM_BYTES, a power of two) is cleared byte by byte in S_CLEAR with tready low
module load_store_unit_exec #(
  parameter int unsigned MEM_BYTES = lsu_pkg::MEM_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // instruction, pc, reg_index, mem_address, write_value, zero pad
  input  wire logic [lsu_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  wire logic [1:0]                     s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // effective_address, transfer_data
  output logic      [lsu_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // was_load
  output logic      [0:0]                     m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [AW:0]   MEM_SIZE = (AW+1)'(MEM_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_BYTES - 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLEAR = 12'b000000000010,
    S_PRE   = 12'b000000000100,
    S_RDN   = 12'b000000001000,
    S_RDM   = 12'b000000010000,
    S_ADDR  = 12'b000000100000,
    S_WB    = 12'b000001000000,
    S_RDT   = 12'b000010000000,
    S_GETT  = 12'b000100000000,
    S_MEM   = 12'b001000000000,
    S_RFW   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // captured word
  logic [1:0]  kind_q;
  logic [31:0] instr_q;
  logic [63:0] pc_q;
  logic [4:0]  reg_index_q;
  logic [63:0] write_value_q;

  // working registers
  logic [63:0]   base_q, addr_q, wb_q, data_q;
  logic [AW-1:0] idx_q, clr_cnt_q;
  logic [3:0]    byte_cnt_q;
  logic          load_q;
  logic [31:0]   rf_vld_q;
  logic [4:0]    rf_ridx_q;

  logic          m_valid_q;
  logic [63:0]   m_addr_q, m_data_q;
  logic          m_load_q;

  // decode
  logic        grp, wide, uoff, ld, roff, pre, wb_mode, post, is_load;
  logic [4:0]  rt, xn, xm;
  logic [3:0]  size;

  assign grp     = instr_q[lsu_pkg::BIT_GROUP];
  assign wide    = instr_q[lsu_pkg::BIT_WIDE];
  assign uoff    = instr_q[lsu_pkg::BIT_UOFF];
  assign ld      = instr_q[lsu_pkg::BIT_LOAD];
  assign roff    = instr_q[lsu_pkg::BIT_ROFF];
  assign pre     = instr_q[lsu_pkg::BIT_PRE];
  assign rt      = instr_q[4:0];
  assign xn      = instr_q[9:5];
  assign xm      = instr_q[20:16];
  assign wb_mode = grp && !uoff && !roff;
  assign post    = wb_mode && !pre;
  assign is_load = !grp || ld;
  assign size    = wide ? 4'd8 : 4'd4;

  logic s_acc;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  logic [63:0] s_maddr;
  assign s_maddr = {48'b0, s_axis_tdata_i[116:101]};

  // register file
  logic        rf_we;
  logic [4:0]  rf_waddr, rf_raddr;
  logic [63:0] rf_wdata, rf_rdata, rf_eff;

  lsu_ram #(
    .WIDTH(lsu_pkg::DATA_W),
    .DEPTH(lsu_pkg::NUM_REGS)
  ) u_rf (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(rf_waddr),
    .wdata_i(rf_wdata),
    .raddr_i(rf_raddr),
    .rdata_o(rf_rdata)
  );

  assign rf_eff = rf_vld_q[rf_ridx_q] ? rf_rdata : '0;

  // byte memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata, mem_rdata;

  lsu_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(idx_q),
    .rdata_o(mem_rdata)
  );

  // shared adder
  logic [63:0] opa, opb, sum, addr_next;
  always_comb begin
    opa = grp ? base_q : pc_q;
    if (!grp) begin
      opb = lsu_pkg::sext19x4(instr_q[23:5]);
    end else if (uoff) begin
      opb = wide ? {49'b0, instr_q[21:10], 3'b000} : {50'b0, instr_q[21:10], 2'b00};
    end else if (roff) begin
      opb = rf_eff;
    end else begin
      opb = lsu_pkg::sext9(instr_q[20:12]);
    end
  end
  assign sum       = opa + opb;
  assign addr_next = post ? base_q : sum;

  logic [AW:0]   idx_inc;
  logic [AW-1:0] idx_wrap;
  assign idx_inc  = {1'b0, idx_q} + {{AW{1'b0}}, 1'b1};
  assign idx_wrap = (idx_inc == MEM_SIZE) ? '0 : idx_inc[AW-1:0];

  logic [2:0] byte_sel, byte_prev;
  assign byte_sel  = byte_cnt_q[2:0];
  assign byte_prev = byte_sel - 3'd1;

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_cnt_q == LAST_IDX) state_d = S_IDLE;
      S_IDLE: begin
        if (s_acc) begin
          state_d = (s_axis_tuser_i == lsu_pkg::KIND_EXEC) ? S_RDN : S_PRE;
        end
      end
      S_RDN:  state_d = S_RDM;
      S_RDM:  state_d = S_ADDR;
      S_ADDR: state_d = wb_mode ? S_WB : (is_load ? S_MEM : S_RDT);
      S_WB:   state_d = is_load ? S_MEM : S_RDT;
      S_RDT:  state_d = S_GETT;
      S_GETT: state_d = S_MEM;
      S_MEM:  if (byte_cnt_q == size) state_d = is_load ? S_RFW : S_DONE;
      S_RFW:  state_d = S_DONE;
      S_PRE:  state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // port muxes
  always_comb begin
    rf_raddr = xn;
    if (state_q == S_RDM) begin
      rf_raddr = xm;
    end else if (state_q == S_RDT) begin
      rf_raddr = rt;
    end
    rf_we    = 1'b0;
    rf_waddr = rt;
    rf_wdata = data_q;
    if (state_q == S_PRE && kind_q == lsu_pkg::KIND_WREG) begin
      rf_we    = 1'b1;
      rf_waddr = reg_index_q;
      rf_wdata = write_value_q;
    end else if (state_q == S_WB) begin
      rf_we    = 1'b1;
      rf_waddr = xn;
      rf_wdata = wb_q;
    end else if (state_q == S_RFW) begin
      rf_we = 1'b1;
    end
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = data_q[8*byte_sel +: 8];
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (state_q == S_PRE && kind_q == lsu_pkg::KIND_WMEM) begin
      mem_we    = 1'b1;
      mem_wdata = write_value_q[7:0];
    end else if (state_q == S_MEM && !is_load && byte_cnt_q < size) begin
      mem_we = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      rf_vld_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rf_ridx_q <= rf_raddr;
    if (s_acc) begin
      kind_q        <= s_axis_tuser_i;
      instr_q       <= s_axis_tdata_i[31:0];
      pc_q          <= s_axis_tdata_i[95:32];
      reg_index_q   <= s_axis_tdata_i[100:96];
      write_value_q <= s_axis_tdata_i[180:117];
      idx_q         <= s_maddr[AW-1:0];
    end
    unique case (state_q)
      S_RDM: base_q <= rf_eff;
      S_ADDR: begin
        addr_q     <= addr_next;
        idx_q      <= addr_next[AW-1:0];
        wb_q       <= sum;
        load_q     <= is_load;
        data_q     <= '0;
        byte_cnt_q <= '0;
      end
      S_GETT: data_q <= wide ? rf_eff : {32'b0, rf_eff[31:0]};
      S_MEM: begin
        if (byte_cnt_q < size) begin
          byte_cnt_q <= byte_cnt_q + 4'd1;
          idx_q      <= idx_wrap;
        end
        if (is_load && byte_cnt_q != 4'd0) begin
          data_q[8*byte_prev +: 8] <= mem_rdata;
        end
      end
      S_PRE: begin
        addr_q <= '0;
        data_q <= '0;
        load_q <= 1'b0;
      end
      S_DONE: begin
        if (out_free) begin
          m_addr_q <= addr_q;
          m_data_q <= data_q;
          m_load_q <= load_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_data_q, m_addr_q};
  assign m_axis_tuser_o  = m_load_q;

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("accepted a second word while busy");

  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEM) |-> (byte_cnt_q <= size))
    else $error("byte count beyond access size");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEM) |-> ({1'b0, idx_q} < MEM_SIZE))
    else $error("memory index out of range");

  a_mem_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (MEM_BYTES & (MEM_BYTES - 1)) == 0)
    else $error("memory size not a power of two");

endmodule
`default_nettype wire

// ===== tb/load_store_unit_exec_test.sv =====
`default_nettype none
module load_store_unit_exec_test;
  import lsu_pkg::*;

  localparam int unsigned MEM_SIZE = MEM_BYTES_DEF;
  localparam int unsigned RANDOM_WORDS = 1250;

  typedef struct packed {
    logic [63:0] addr;
    logic        loaded;
    logic [63:0] data;
  } xfer_t;

  class transfer_predictor;
    bit [63:0] regs [NUM_REGS];
    bit [7:0]  mem  [MEM_SIZE];
    xfer_t     due_transfers [$];
    int        mismatches;
    int        loads;
    int        stores;
    int        preloads;
    int        results_seen;

    function void note_word(kind_e k, bit [31:0] ins, bit [63:0] pc, bit [4:0] ri,
                            bit [15:0] ma, bit [63:0] wv);
      xfer_t     r;
      bit [63:0] off;
      bit        wide;
      bit        ld;
      int        nbytes;
      r = '0;
      case (k)
        KIND_WREG: begin
          regs[ri] = wv;
          preloads++;
        end
        KIND_WMEM: begin
          mem[ma % MEM_SIZE] = wv[7:0];
          preloads++;
        end
        KIND_EXEC: begin
          wide = ins[BIT_WIDE];
          nbytes = wide ? 8 : 4;
          ld = ins[BIT_LOAD];
          if (ins[BIT_GROUP]) begin
            if (ins[BIT_UOFF]) begin
              r.addr = regs[ins[9:5]] + (64'(ins[21:10]) << (wide ? 3 : 2));
            end else if (ins[BIT_ROFF]) begin
              r.addr = regs[ins[9:5]] + regs[ins[20:16]];
            end else begin
              off = {{55{ins[20]}}, ins[20:12]};
              if (ins[BIT_PRE]) begin
                r.addr = regs[ins[9:5]] + off;
                regs[ins[9:5]] = r.addr;
              end else begin
                r.addr = regs[ins[9:5]];
                regs[ins[9:5]] = r.addr + off;
              end
            end
          end else begin
            // literal group always loads
            ld = 1'b1;
            r.addr = pc + {{43{ins[23]}}, ins[23:5], 2'b00};
          end
          r.loaded = ld;
          if (ld) begin
            for (int i = 0; i < nbytes; i++) r.data[8*i +: 8] = mem[(r.addr + i) % MEM_SIZE];
            regs[ins[4:0]] = r.data;
            loads++;
          end else begin
            r.data = wide ? regs[ins[4:0]] : {32'h0, regs[ins[4:0]][31:0]};
            for (int i = 0; i < nbytes; i++) mem[(r.addr + i) % MEM_SIZE] = r.data[8*i +: 8];
            stores++;
          end
        end
        default: ;
      endcase
      due_transfers.push_back(r);
    endfunction

    function void check_transfer(bit [63:0] addr, bit loaded, bit [63:0] data);
      xfer_t e;
      results_seen++;
      if (due_transfers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: addr %h load %b data %h", addr, loaded, data);
        return;
      end
      e = due_transfers.pop_front();
      if (e.addr !== addr || e.loaded !== loaded || e.data !== data) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected addr %h load %b data %h, got addr %h load %b data %h",
                   results_seen, e.addr, e.loaded, e.data, addr, loaded, data);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // instruction, pc, reg_index, mem_address, write_value, zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  // kind
  logic [1:0]           s_axis_tuser_i = KIND_EXEC;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // effective_address, transfer_data
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  // was_load
  logic [0:0]           m_axis_tuser_o;

  transfer_predictor tp = new();
  bit steady = 1'b0;

  load_store_unit_exec uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i)
      tp.check_transfer(m_axis_tdata_o[63:0], m_axis_tuser_o[0], m_axis_tdata_o[127:64]);
    m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 28);
  end

  function automatic bit [31:0] enc_imm12(bit wide, bit ld, bit [11:0] imm, bit [4:0] xn,
                                          bit [4:0] rt);
    return {1'b1, wide, 5'b0, 1'b1, 1'b0, ld, imm, xn, rt};
  endfunction

  function automatic bit [31:0] enc_reg(bit wide, bit ld, bit [4:0] xm, bit [4:0] xn,
                                        bit [4:0] rt);
    return {1'b1, wide, 5'b0, 1'b0, 1'b0, ld, 1'b1, xm, 6'b0, xn, rt};
  endfunction

  function automatic bit [31:0] enc_simm9(bit wide, bit ld, bit [8:0] simm, bit pre,
                                          bit [4:0] xn, bit [4:0] rt);
    return {1'b1, wide, 5'b0, 1'b0, 1'b0, ld, 1'b0, simm, pre, 1'b0, xn, rt};
  endfunction

  function automatic bit [31:0] enc_lit(bit wide, bit [18:0] simm, bit [4:0] rt);
    return {1'b0, wide, 6'b0, simm, rt};
  endfunction

  task automatic send_word(kind_e k, bit [31:0] ins, bit [63:0] pc, bit [4:0] ri,
                           bit [15:0] ma, bit [63:0] wv);
    while (!steady && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b0, wv, ma, ri, pc, ins};
    s_axis_tuser_i  <= k;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tp.note_word(k, ins, pc, ri, ma, wv);
  endtask

  task automatic send_exec(bit [31:0] ins, bit [63:0] pc);
    send_word(KIND_EXEC, ins, pc, 5'd0, 16'd0, 64'd0);
  endtask

  task automatic send_wreg(bit [4:0] ri, bit [63:0] wv);
    send_word(KIND_WREG, 32'd0, 64'd0, ri, 16'd0, wv);
  endtask

  task automatic send_wmem(bit [15:0] ma, bit [63:0] wv);
    send_word(KIND_WMEM, 32'd0, 64'd0, 5'd0, ma, wv);
  endtask

  initial begin
    int          sel;
    bit [31:0]   ins;
    bit [63:0]   pc;
    bit [63:0]   wv;
    kind_e       k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every mode, wrap and writeback corner cases
    send_wreg(5'd0, 64'h1000);
    send_wreg(5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
    send_wreg(5'd5, 64'h0123_4567_89AB_CDEF);
    send_wmem(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFA5);
    send_wmem(16'h0000, 64'h5A);
    send_exec(enc_imm12(1'b1, 1'b0, 12'hFFF, 5'd0, 5'd5), 64'd0);
    send_exec(enc_imm12(1'b1, 1'b1, 12'hFFF, 5'd0, 5'd7), 64'd0);
    send_exec(enc_imm12(1'b0, 1'b0, 12'h000, 5'd31, 5'd5), 64'd0);
    send_exec(enc_imm12(1'b0, 1'b1, 12'h000, 5'd31, 5'd8), 64'd0);
    send_exec(enc_reg(1'b1, 1'b1, 5'd31, 5'd0, 5'd9), 64'd0);
    send_exec(enc_reg(1'b0, 1'b0, 5'd5, 5'd5, 5'd31), 64'd0);
    send_exec(enc_simm9(1'b1, 1'b0, 9'h100, 1'b1, 5'd0, 5'd5), 64'd0);
    send_exec(enc_simm9(1'b1, 1'b1, 9'h0FF, 1'b0, 5'd0, 5'd0), 64'd0);
    send_exec(enc_simm9(1'b0, 1'b0, 9'h1FF, 1'b1, 5'd3, 5'd3), 64'd0);
    send_exec(enc_simm9(1'b0, 1'b1, 9'h001, 1'b1, 5'd31, 5'd31), 64'd0);
    send_exec(enc_lit(1'b1, 19'h40000, 5'd10), 64'd0);
    send_exec(enc_lit(1'b0, 19'h3FFFF, 5'd11), 64'hFFFF_FFFF_FFFF_FFFF);
    send_exec(enc_lit(1'b1, 19'h00004, 5'd12), 64'h100);
    send_wreg(5'd31, 64'd0);
    send_exec(32'hFFFF_FFFF, 64'd0);
    send_exec(32'h0000_0000, 64'd0);

    // random: all fields random, kind decides which ones matter
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= 450 && n < 750);
      sel = $urandom_range(0, 99);
      k = (sel < 12) ? KIND_WREG : (sel < 20) ? KIND_WMEM : KIND_EXEC;
      ins = $urandom;
      if ($urandom_range(0, 99) < 80) ins[BIT_GROUP] = 1'b1;
      if ($urandom_range(0, 9) == 0) ins[4:0] = ins[9:5];
      case ($urandom_range(0, 3))
        0, 1: pc = 64'($urandom_range(0, 65535));
        2: pc = {$urandom, $urandom};
        default: pc = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 4))
        0, 1, 2: wv = 64'($urandom_range(0, 8191));
        3: wv = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 65535));
        default: wv = {$urandom, $urandom};
      endcase
      send_word(k, ins, pc, 5'($urandom), 16'($urandom), wv);
    end
    steady = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    while (tp.due_transfers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("covered %0d results: %0d loads, %0d stores, %0d preloads",
             tp.results_seen, tp.loads, tp.stores, tp.preloads);
    $display("all four offset modes and literal loads, with address wrap and base writeback");
    if (tp.mismatches == 0) begin
      $display("[load_store_unit_exec] OK");
    end else begin
      $display("%0d mismatches", tp.mismatches);
      $display("[load_store_unit_exec] ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("[load_store_unit_exec] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== load_store_unit_exec.f =====
rtl/core/lsu_pkg.sv
rtl/core/lsu_ram.sv
rtl/core/load_store_unit_exec.sv
tb/load_store_unit_exec_test.sv
